// File: hdl/htq_pkg.sv
// ----------------------------------------------------------------------------
// htq_pkg
// Types and constants shared by the heap timer queue.
// ----------------------------------------------------------------------------
package htq_pkg;

  localparam int unsigned DefCapacity    = 256;
  localparam int unsigned DefMaxFire     = 64;
  localparam int unsigned NumIds         = 256;
  localparam int unsigned IdW            = 8;
  localparam int unsigned TimeW          = 64;
  localparam int unsigned CapW           = 9;
  localparam logic [CapW-1:0] CapReset   = 9'd256;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TICK,
    S_DEL_LAST,
    S_SU_READ,
    S_SU_CMP,
    S_SD_LEFT,
    S_SD_RIGHT,
    S_SD_CMP,
    S_EMIT
  } fsm_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IdW-1:0]   timer_id;
    logic [TimeW-1:0] time_value;
    logic [6:0]       fire_limit;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             fired_valid;
    logic [IdW-1:0]   fired_id;
    logic [TimeW-1:0] fired_time;
    logic             last_result;
    logic [8:0]       pending_count;
    logic [TimeW-1:0] earliest_time;
    logic             queue_empty;
  } rsp_t;

  typedef struct packed {
    logic [TimeW-1:0] key;
    logic [IdW-1:0]   id;
  } heap_ent_t;

endpackage

// File: hdl/heap_timer_queue.sv
// ----------------------------------------------------------------------------
// heap_timer_queue
// Timer queue kept as a binary min-heap in block memory.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. A rejected request passes through accept,
// decode and emit. An add climbs with a parent read and a compare per level. A
// delete, and each timer fired by a tick, reads the last entry and sifts it
// down with three steps per level (left child, right child, compare), then back
// up with a read and a compare per level; the heap memory has one read port.
// Each fired timer gives one response; a response waiting in the output
// register holds the sequencer until it is taken. The id-to-slot table has one
// pending bit per id in flip-flops, so no clearing pass follows reset.
module heap_timer_queue
  import htq_pkg::*;
#(
  parameter int unsigned CAPACITY          = DefCapacity,
  parameter int unsigned MAX_FIRE_PER_TICK = DefMaxFire
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  req_t            in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rsp_t            out_rsp_o,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i
);

  localparam int unsigned SW = $clog2(CAPACITY + 1);
  localparam logic [SW-1:0] CapSw = SW'(CAPACITY);
  localparam logic [6:0] MaxFire = 7'(MAX_FIRE_PER_TICK);

  heap_ent_t heap_mem [CAPACITY+1];
  logic [SW-1:0] slot_mem [NumIds];

  fsm_e state_q, state_d;
  req_t req_q;
  logic [CapW-1:0] cap_q;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] pos_q, pos_d;
  heap_ent_t mov_q, mov_d;
  heap_ent_t left_q, left_d;
  logic right_ok_q, right_ok_d;
  heap_ent_t root_q;
  logic [6:0] lim_q, lim_d;
  logic [6:0] fired_q, fired_d;
  logic [1:0] st_q, st_d;
  logic fv_q, fv_d;
  heap_ent_t fent_q, fent_d;
  logic [NumIds-1:0] pend_q, pend_d;

  heap_ent_t heap_rd_q;
  logic [SW-1:0] slot_rd_q;
  logic heap_re, heap_we, slot_re, slot_we;
  logic [SW-1:0] heap_ra, heap_wa, slot_wd;
  heap_ent_t heap_wd;
  logic [IdW-1:0] slot_a;

  logic out_valid_q;
  rsp_t out_q;
  logic out_load;
  logic out_free;

  logic [SW:0] child_l, child_r, n_ext;
  logic [TimeW-1:0] diff;
  logic root_expired, full, tick_last, emit_last;
  heap_ent_t child;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign child_l = {pos_q, 1'b0};
  assign child_r = child_l + (SW+1)'(1);
  assign n_ext   = {1'b0, cnt_q};
  assign diff    = root_q.key - req_q.time_value;
  assign root_expired = (diff == '0) || diff[TimeW-1];
  assign full = (cnt_q >= CapSw) || (32'(cnt_q) >= 32'(cap_q));
  assign child = (right_ok_q && (left_q.key > heap_rd_q.key)) ? heap_rd_q : left_q;
  assign tick_last = ((fired_q + 7'd1) == lim_q) || (cnt_q == '0) || !root_expired;
  assign emit_last = (req_q.opcode == OP_TICK && fv_q) ? tick_last : 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (req_q.opcode)
          OP_ADD: state_d = (full || pend_q[req_q.timer_id]) ? S_EMIT : S_SU_READ;
          OP_DEL: state_d = pend_q[req_q.timer_id] ? S_DEL_LAST : S_EMIT;
          OP_TICK: state_d = S_TICK;
          default: state_d = S_EMIT;
        endcase
      end
      S_TICK: begin
        if (fired_q < lim_q && cnt_q != '0 && root_expired) state_d = S_DEL_LAST;
        else state_d = S_EMIT;
      end
      S_DEL_LAST: begin
        if (pos_d == cnt_q) state_d = S_EMIT;
        else state_d = S_SD_LEFT;
      end
      S_SU_READ: begin
        state_d = (pos_q > SW'(1)) ? S_SU_CMP : S_EMIT;
      end
      S_SU_CMP: begin
        state_d = (heap_rd_q.key > mov_q.key) ? S_SU_READ : S_EMIT;
      end
      S_SD_LEFT: begin
        state_d = (child_l <= n_ext) ? S_SD_RIGHT : S_SU_READ;
      end
      S_SD_RIGHT: state_d = S_SD_CMP;
      S_SD_CMP: state_d = (mov_q.key > child.key) ? S_SD_LEFT : S_SU_READ;
      S_EMIT: begin
        if (out_free) state_d = emit_last ? S_IDLE : S_TICK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    mov_d = mov_q;
    left_d = left_q;
    right_ok_d = right_ok_q;
    lim_d = lim_q;
    fired_d = fired_q;
    st_d = st_q;
    fv_d = fv_q;
    fent_d = fent_q;
    pend_d = pend_q;
    heap_re = 1'b0;
    heap_ra = cnt_q;
    heap_we = 1'b0;
    heap_wa = pos_q;
    heap_wd = mov_q;
    slot_re = 1'b0;
    slot_we = 1'b0;
    slot_a = req_q.timer_id;
    slot_wd = pos_q;
    out_load = 1'b0;
    case (state_q)
      S_DECODE: begin
        st_d = ST_OK;
        fv_d = 1'b0;
        fired_d = '0;
        lim_d = (req_q.fire_limit == '0 || req_q.fire_limit > MaxFire) ?
                MaxFire : req_q.fire_limit;
        mov_d = '{key: req_q.time_value, id: req_q.timer_id};
        case (req_q.opcode)
          OP_ADD: begin
            if (full) st_d = ST_FULL;
            else if (pend_q[req_q.timer_id]) st_d = ST_INVALID;
            else begin
              cnt_d = cnt_q + SW'(1);
              pos_d = cnt_q + SW'(1);
            end
          end
          OP_DEL: begin
            if (!pend_q[req_q.timer_id]) st_d = ST_INVALID;
            else begin
              // fetch the victim's slot and the last entry together
              pend_d[req_q.timer_id] = 1'b0;
              slot_re = 1'b1;
              heap_re = 1'b1;
            end
          end
          OP_TICK: ;
          default: st_d = ST_INVALID;
        endcase
      end
      S_TICK: begin
        fv_d = 1'b0;
        if (fired_q < lim_q && cnt_q != '0 && root_expired) begin
          fv_d = 1'b1;
          fent_d = root_q;
          pend_d[root_q.id] = 1'b0;
          heap_re = 1'b1;
        end
      end
      S_DEL_LAST: begin
        pos_d = (req_q.opcode == OP_TICK) ? SW'(1) : slot_rd_q;
        mov_d = heap_rd_q;
        cnt_d = cnt_q - SW'(1);
      end
      S_SU_READ: begin
        if (pos_q > SW'(1)) begin
          heap_re = 1'b1;
          heap_ra = pos_q >> 1;
        end else begin
          heap_we = 1'b1;
          slot_we = 1'b1;
          slot_a = mov_q.id;
          pend_d[mov_q.id] = 1'b1;
        end
      end
      S_SU_CMP: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
        if (heap_rd_q.key > mov_q.key) begin
          // pull the parent down and climb
          heap_wd = heap_rd_q;
          slot_a = heap_rd_q.id;
          pos_d = pos_q >> 1;
        end else begin
          slot_a = mov_q.id;
          pend_d[mov_q.id] = 1'b1;
        end
      end
      S_SD_LEFT: begin
        if (child_l <= n_ext) begin
          heap_re = 1'b1;
          heap_ra = child_l[SW-1:0];
        end
      end
      S_SD_RIGHT: begin
        left_d = heap_rd_q;
        right_ok_d = (child_r <= n_ext);
        heap_re = (child_r <= n_ext);
        heap_ra = child_r[SW-1:0];
      end
      S_SD_CMP: begin
        if (mov_q.key > child.key) begin
          heap_we = 1'b1;
          heap_wd = child;
          slot_we = 1'b1;
          slot_a = child.id;
          pos_d = (right_ok_q && (left_q.key > heap_rd_q.key)) ?
                  child_r[SW-1:0] : child_l[SW-1:0];
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!emit_last) fired_d = fired_q + 7'd1;
        end
      end
      default: ;
    endcase
  end

  // heap and slot memories
  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (heap_re) heap_rd_q <= heap_mem[heap_ra];
    if (slot_we) slot_mem[slot_a] <= slot_wd;
    if (slot_re) slot_rd_q <= slot_mem[slot_a];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) req_q <= in_req_i;
    pos_q <= pos_d;
    mov_q <= mov_d;
    left_q <= left_d;
    right_ok_q <= right_ok_d;
    lim_q <= lim_d;
    st_q <= st_d;
    fent_q <= fent_d;
    // mirror slot one so the root is always at hand
    if (heap_we && heap_wa == SW'(1)) root_q <= heap_wd;
    if (out_load) begin
      out_q.status        <= st_q;
      out_q.fired_valid   <= fv_q;
      out_q.fired_id      <= fv_q ? fent_q.id : '0;
      out_q.fired_time    <= fv_q ? fent_q.key : '0;
      out_q.last_result   <= emit_last;
      out_q.pending_count <= 9'(cnt_q);
      out_q.earliest_time <= (cnt_q != '0) ? root_q.key : '0;
      out_q.queue_empty   <= (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      pend_q <= '0;
      fired_q <= '0;
      fv_q <= 1'b0;
      cap_q <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      pend_q <= pend_d;
      fired_q <= fired_d;
      fv_q <= fv_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule
